// ----- rtl/manual_pwm_override_lock_macros.svh -----
// Assertion macros for the manual PWM override lock block.
`ifndef MANUAL_PWM_OVERRIDE_LOCK_MACROS_SVH
`define MANUAL_PWM_OVERRIDE_LOCK_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MPOL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define MPOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MPOL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MPOL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/mpol_pkg.sv -----
// Types, constants and the knob scaling function of the override lock.
`timescale 1ns / 1ps
package mpol_pkg;

  localparam int unsigned ElapsedW = 16;
  localparam int unsigned KnobW    = 12;
  localparam int unsigned PwmW     = 16;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = KnobW + PwmW;

  localparam logic [HoldW-1:0] HoldMax        = 16'd60000;
  localparam logic [KnobW-1:0] KnobMax        = 12'd4095;
  localparam logic [PwmW-1:0]  FullScaleReset = 16'hFFFF;
  localparam logic [PwmW-1:0]  MarginReset    = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFullScale = 2'd0,
    CfgMargin    = 2'd1,
    CfgLaser     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LedOff   = 2'd0,
    LedOn    = 2'd1,
    LedBlink = 2'd2
  } led_mode_e;

  typedef struct packed {
    logic [ElapsedW-1:0] elapsed_ms;
    logic                button_down;
    logic [KnobW-1:0]    knob_sample;
    logic [PwmW-1:0]     auto_pwm;
  } in_word_t;

  typedef struct packed {
    logic             override_active;
    logic [PwmW-1:0]  override_value;
    logic [1:0]       led_mode;
    logic [HoldW-1:0] hold_time;
  } out_word_t;

  // floor(avg * fs / 4095): since 4095 = 2^12 - 1, the quotient estimate
  // x/4096 + x/2^24 + x/2^36 is low by at most one; one compare fixes it.
  function automatic logic [PwmW-1:0] scale_knob(input logic [KnobW-1:0] avg,
                                                 input logic [PwmW-1:0]  fs);
    logic [ProdW-1:0] prod;
    logic [ProdW:0]   est;
    logic [PwmW-1:0]  q0;
    logic [ProdW:0]   rem;
    prod = {{PwmW{1'b0}}, avg} * {{KnobW{1'b0}}, fs};
    est  = {1'b0, prod} + {13'd0, prod[ProdW-1:12]} + {25'd0, prod[ProdW-1:24]};
    q0   = est[ProdW-1:12];
    rem  = {1'b0, prod} - {1'b0, q0, 12'd0} + {13'd0, q0};
    if (rem >= {17'd0, KnobMax}) begin
      scale_knob = q0 + 16'd1;
    end else begin
      scale_knob = q0;
    end
  endfunction

endpackage

// ----- rtl/mpol_if.sv -----
// Valid/ready channel carrying one word of a packed payload type.
`timescale 1ns / 1ps
interface mpol_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/manual_pwm_override_lock.sv -----
// Manual spindle PWM override with speed-matched lock: top level.
// A word is registered on accept and moves into the state once the output register frees.
// Throughput: one word per cycle while the output is ready; the knob multiply and
//   the divide by 4095 and the lock compare are combinational between in_q and the state.
// Reset (rst_ni low, asynchronous): override off, average, hold time and LED cleared,
//   registers back to full scale 65535, margin 500, laser mode off.
`timescale 1ns / 1ps
module manual_pwm_override_lock (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpol_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mpol_pkg::CfgDataW-1:0]  cfg_wdata_i,
  mpol_if.sink                           in_i,
  mpol_if.source                         out_o
);
  import mpol_pkg::*;

  `include "manual_pwm_override_lock_macros.svh"

  // Configuration registers
  logic [PwmW-1:0] full_scale_q;
  logic [PwmW-1:0] margin_q;
  logic            laser_q;

  // Input register and result valid
  in_word_t in_q;
  logic     in_valid_q;
  logic     out_valid_q, out_valid_d;

  // Block state; it doubles as the result register since the result is
  // exactly the state after the step.
  logic [KnobW-1:0] knob_avg_q, knob_avg_d;
  logic [PwmW-1:0]  manual_q, manual_d;
  logic             active_q, active_d;
  logic             request_q, request_d;
  logic [HoldW-1:0] held_q, held_d;
  led_mode_e        led_q, led_d;

  logic             fire;
  logic [KnobW-1:0] avg_new;
  logic [PwmW-1:0]  manual_new;
  logic             req_new;
  logic [PwmW:0]    engage_lhs;
  logic [PwmW:0]    release_rhs;
  logic [HoldW:0]   held_sum;

  // A word moves from the input register into the state when the result
  // register is free or being drained this cycle.
  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FullScaleReset;
      margin_q     <= MarginReset;
      laser_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFullScale: full_scale_q <= cfg_wdata_i;
        CfgMargin:    margin_q     <= cfg_wdata_i;
        CfgLaser:     laser_q      <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // Knob path: new average, then scale to PWM full scale.
  assign avg_new    = KnobW'(({1'b0, knob_avg_q} + {1'b0, in_q.knob_sample}) >> 1);
  assign manual_new = scale_knob(avg_new, full_scale_q);

  // First update of a press asks for the opposite of the present state.
  assign req_new = (held_q == '0) ? !active_q : request_q;

  // 17-bit sums so the lock compares never wrap.
  assign engage_lhs  = {1'b0, in_q.auto_pwm} + {1'b0, margin_q};
  assign release_rhs = {1'b0, manual_new} + {1'b0, margin_q};
  assign held_sum    = {1'b0, held_q} + {1'b0, in_q.elapsed_ms};

  always_comb begin
    knob_avg_d  = knob_avg_q;
    manual_d    = manual_q;
    active_d    = active_q;
    request_d   = request_q;
    held_d      = held_q;
    led_d       = led_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      // zero elapsed time leaves everything as it is
      if (in_q.elapsed_ms != '0) begin
        priority if (laser_q) begin
          active_d = 1'b0;
          held_d   = '0;
          led_d    = LedOff;
        end else if (in_q.button_down) begin
          request_d  = req_new;
          knob_avg_d = avg_new;
          manual_d   = manual_new;
          if (req_new != active_q) begin
            // not locked yet: blink, lock when the values meet
            led_d = LedBlink;
            if (req_new) begin
              active_d = (engage_lhs >= {1'b0, manual_new});
            end else begin
              active_d = ({1'b0, in_q.auto_pwm} >= release_rhs);
            end
          end else begin
            led_d = active_q ? LedOn : LedOff;
          end
          held_d = (held_sum > {1'b0, HoldMax}) ? HoldMax : held_sum[HoldW-1:0];
        end else begin
          held_d = '0;
          if (active_q) begin
            knob_avg_d = avg_new;
            manual_d   = manual_new;
            led_d      = LedOn;
          end else begin
            led_d = LedOff;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knob_avg_q  <= '0;
      manual_q    <= '0;
      active_q    <= 1'b0;
      request_q   <= 1'b0;
      held_q      <= '0;
      led_q       <= LedOff;
      out_valid_q <= 1'b0;
    end else begin
      knob_avg_q  <= knob_avg_d;
      manual_q    <= manual_d;
      active_q    <= active_d;
      request_q   <= request_d;
      held_q      <= held_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.data.override_active = active_q;
  assign out_o.data.override_value  = manual_q;
  assign out_o.data.led_mode        = led_q;
  assign out_o.data.hold_time       = held_q;

  // Steady LED means engaged; dark LED means released.
  `MPOL_ASSERT_NOW(a_led_on_active, clk_i, rst_ni, led_q == LedOn, active_q)
  `MPOL_ASSERT_NOW(a_led_off_idle, clk_i, rst_ni, led_q == LedOff, !active_q)
  `MPOL_ASSERT_NOW(a_hold_sat, clk_i, rst_ni, 1'b1, held_q <= HoldMax)
  // Laser mode always drops the override on a timed update.
  `MPOL_ASSERT_NEXT(a_laser_off, clk_i, rst_ni,
                    fire && laser_q && (in_q.elapsed_ms != '0),
                    !active_q && (held_q == '0))

endmodule
